>>> src/tbsc_pkg.sv
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types and constants for the triple buffered sample capture block.
// ----------------------------------------------------------------------------
package tbsc_pkg;

  localparam int DEF_BUFFER_LEN   = 25;
  localparam int DEF_BUFFER_COUNT = 3;
  localparam int DEF_RING_DEPTH   = 10;

  localparam int AXIS_W  = 16;
  localparam int WORD_W  = 3 * AXIS_W + 1;  // x, y, z and the pressed flag
  localparam int LIMIT_W = 12;
  localparam int BUF_W   = 2;               // covers up to four buffers

  localparam logic [7:0]         STATUS_MASK = 8'd65;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2500;

  // command codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] status_byte;
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
    logic       button_pin;
  } in_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x_value;
    logic signed [AXIS_W-1:0] y_value;
    logic signed [AXIS_W-1:0] z_value;
    logic                     pressed;
    logic [BUF_W-1:0]         buffer_number;
    logic                     last;
    logic                     capture_done;
  } out_item_t;

endpackage

>>> src/triple_buffer_sample_capture.sv
// Capture transaction: accepted whenever the block is idle.
// Drain transaction: the ready ring is read, then the store, and the first result is
//   registered in the output register; then one result per cycle while out_ready is high,
//   BUFFER_LEN results in all; the next input is taken once the last result is registered.
// Reset is synchronous, active low: pointers, counters and control clear, the limit
//   returns to 2500. The sample store and ready ring RAMs are not cleared.
// ----------------------------------------------------------------------------
// triple_buffer_sample_capture
// Captures sensor samples into rotating buffers held in RAM, queues full
// buffers on a ready ring and streams the oldest ready buffer on request.
// ----------------------------------------------------------------------------
module triple_buffer_sample_capture #(
  parameter int BUFFER_LEN   = tbsc_pkg::DEF_BUFFER_LEN,
  parameter int BUFFER_COUNT = tbsc_pkg::DEF_BUFFER_COUNT,
  parameter int RING_DEPTH   = tbsc_pkg::DEF_RING_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tbsc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tbsc_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbsc_pkg::LIMIT_W-1:0]  cfg_data
);
  import tbsc_pkg::*;

  localparam int STORE_DEPTH = BUFFER_COUNT * BUFFER_LEN;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int FILL_W      = (BUFFER_LEN > 1) ? $clog2(BUFFER_LEN) : 1;
  localparam int RW          = $clog2(RING_DEPTH);

  localparam logic [AW-1:0]     LEN_A     = AW'(BUFFER_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BUFFER_LEN - 1);
  localparam logic [BUF_W-1:0]  BUF_LAST  = BUF_W'(BUFFER_COUNT - 1);
  localparam logic [RW-1:0]     RING_LAST = RW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_RING, S_READ} state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [BUF_W-1:0]    active_r, active_nxt;
  logic [RW-1:0]       head_r, head_nxt;
  logic [RW-1:0]       tail_r, tail_nxt;
  logic [LIMIT_W-1:0]  taken_r, taken_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [BUF_W-1:0]    buf_r, buf_nxt;
  logic                done_r, done_nxt;
  logic [FILL_W-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;

  logic                in_fire;
  logic                cap_ok;
  logic                load_out;
  logic                out_last;
  logic [RW-1:0]       head_inc;
  logic [WORD_W-1:0]   cap_word;
  logic [AW-1:0]       cap_addr;

  logic                store_we, store_re;
  logic [AW-1:0]       store_raddr;
  logic [WORD_W-1:0]   store_rdata;
  logic                ring_we, ring_re;
  logic [BUF_W-1:0]    ring_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cap_ok = in_fire && (in_data.command == CMD_CAPTURE)
                  && ((in_data.status_byte & STATUS_MASK) == STATUS_MASK)
                  && (taken_r < limit_r);

  assign cap_word = {~in_data.button_pin,
                     in_data.z_high, in_data.z_low,
                     in_data.y_high, in_data.y_low,
                     in_data.x_high, in_data.x_low};
  assign cap_addr = AW'(active_r) * LEN_A + AW'(fill_r);
  assign head_inc = (head_r == RING_LAST) ? '0 : head_r + 1'b1;

  assign store_we = cap_ok;
  assign ring_we  = cap_ok && (fill_r == FILL_LAST) && (head_inc != tail_r);

  // output register is free or empties this cycle
  assign load_out = (state_r == S_READ) && (!out_valid_r || out_ready);
  assign out_last = (idx_r == FILL_LAST);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    active_nxt    = active_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    taken_nxt     = taken_r;
    limit_nxt     = cfg_valid ? cfg_data : limit_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    buf_nxt       = buf_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    rd_addr_nxt   = rd_addr_r;
    ring_re       = 1'b0;
    store_re      = 1'b0;
    store_raddr   = rd_addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (cap_ok) begin
          taken_nxt = taken_r + 1'b1;
          if (fill_r == FILL_LAST) begin
            fill_nxt   = '0;
            active_nxt = (active_r == BUF_LAST) ? '0 : active_r + 1'b1;
            if (ring_we) begin
              head_nxt = head_inc;
            end
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end else if (in_fire && (in_data.command == CMD_DRAIN) && (head_r != tail_r)) begin
          ring_re   = 1'b1;
          tail_nxt  = (tail_r == RING_LAST) ? '0 : tail_r + 1'b1;
          done_nxt  = (taken_r >= limit_r);
          state_nxt = S_RING;
        end
      end
      S_RING: begin
        buf_nxt     = ring_rdata;
        store_raddr = AW'(ring_rdata) * LEN_A;
        store_re    = 1'b1;
        rd_addr_nxt = store_raddr;
        idx_nxt     = '0;
        state_nxt   = S_READ;
      end
      S_READ: begin
        if (load_out) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.x_value       = signed'(store_rdata[AXIS_W-1:0]);
          out_data_nxt.y_value       = signed'(store_rdata[2*AXIS_W-1:AXIS_W]);
          out_data_nxt.z_value       = signed'(store_rdata[3*AXIS_W-1:2*AXIS_W]);
          out_data_nxt.pressed       = store_rdata[WORD_W-1];
          out_data_nxt.buffer_number = buf_r;
          out_data_nxt.last          = out_last;
          out_data_nxt.capture_done  = done_r;
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            store_raddr = rd_addr_r + 1'b1;
            store_re    = 1'b1;
            rd_addr_nxt = store_raddr;
            idx_nxt     = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    buf_r      <= buf_nxt;
    done_r     <= done_nxt;
    idx_r      <= idx_nxt;
    rd_addr_r  <= rd_addr_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      active_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      taken_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      active_r    <= active_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      taken_r     <= taken_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tbsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (cap_addr),
    .wdata (cap_word),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  tbsc_ram #(
    .WIDTH (BUF_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head_r),
    .wdata (active_r),
    .re    (ring_re),
    .raddr (tail_r),
    .rdata (ring_rdata)
  );

  // a push always leaves the ring non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |=> (head_r != tail_r))
    else $error("ring empty after push");

  // the last sample of a buffer returns control to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_last) |=> (state_r == S_IDLE) && out_valid_r && out_data_r.last)
    else $error("last sample did not end the drain");

  // results only come out of the store read state
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_READ))
    else $error("result raised outside read state");

  // store reads and writes never overlap with a drain in flight
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> (state_r == S_IDLE) && !store_re)
    else $error("store write during drain");

endmodule

>>> src/tbsc_ram.sv
// ----------------------------------------------------------------------------
// tbsc_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module tbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
